// ----- src/rtdc_pkg.sv -----
// ----------------------------------------------------------------------------
// rtdc_pkg
// Shared types, fixed-point constants and helpers for the RTD code to
// temperature converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rtdc_pkg;

  localparam int FRAC_BITS      = 32;
  localparam int QW             = 64;
  localparam int MAX_ITERATIONS = 30;
  localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
  localparam int SLOPE_SHIFT    = (FRAC_BITS < 20) ? FRAC_BITS : 20;

  // serial unit sizes
  localparam int MUL_CNT_W = $clog2(QW);
  localparam int DIV_W     = QW + FRAC_BITS;
  localparam int ROOT_W    = DIV_W / 2;
  localparam int REM_W     = QW + 2;
  localparam int DS_CNT_W  = $clog2(DIV_W);

  localparam logic [63:0] INT_MAX = {1'b0, {63{1'b1}}};

  localparam logic signed [63:0] Q_ONE   = signed'(64'd1 << FRAC_BITS);
  localparam logic signed [63:0] KA      =
    signed'(((64'd39083 << FRAC_BITS) + 64'd50000) / 64'd100000);
  localparam logic signed [63:0] KB      =
    signed'(((64'd5775 << FRAC_BITS) + 64'd500000) / 64'd1000000);
  localparam logic signed [63:0] KC      =
    signed'(((64'd4183 << FRAC_BITS) + 64'd5000000) / 64'd10000000);
  localparam logic signed [63:0] EPS     =
    signed'(((64'd1 << FRAC_BITS) + 64'd50000000) / 64'd100000000);
  localparam logic signed [63:0] HSTEP   = signed'(64'd1 << (FRAC_BITS - SLOPE_SHIFT));
  localparam logic signed [63:0] T_LIMIT = signed'(64'd40 << FRAC_BITS);
  localparam logic signed [63:0] T_START = signed'(64'd0 - (64'd1 << (FRAC_BITS - 1)));
  localparam logic [63:0]        HALF    = 64'd1 << (FRAC_BITS - 1);

  localparam logic signed [63:0] OUT_HIGH = 64'sd200000;
  localparam logic signed [63:0] OUT_LOW  = -64'sd30000;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FAULT      = 2'd1,
    STATUS_NO_READING = 2'd2
  } rtdc_status_e;

  typedef enum logic [1:0] {
    CFG_NOMINAL    = 2'd0,
    CFG_REFERENCE  = 2'd1,
    CFG_DECIMALS   = 2'd2,
    CFG_FAHRENHEIT = 2'd3
  } rtdc_cfg_e;

  typedef enum logic {
    DS_DIV  = 1'b0,
    DS_SQRT = 1'b1
  } rtdc_ds_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATIO,
    ST_DISC_A,
    ST_DISC_B,
    ST_SQRT,
    ST_QDIV,
    ST_POLY,
    ST_NDIV,
    ST_SCALE,
    ST_FDIV,
    ST_OUT
  } rtdc_state_e;

  typedef struct packed {
    logic [15:0] rtd_word;
    logic [7:0]  fault_status;
  } rtdc_req_t;

  typedef struct packed {
    logic signed [18:0] temperature;
    logic [20:0]        resistance_centiohm;
    rtdc_status_e       status;
    logic [7:0]         fault_bits;
  } rtdc_rsp_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic signed [63:0] with_sign(input logic [63:0] m, input logic neg);
    logic [63:0] c;
    c = (m > INT_MAX) ? INT_MAX : m;
    return neg ? signed'(64'd0 - c) : signed'(c);
  endfunction

  // truncated fixed-point product from the raw magnitude product
  function automatic logic signed [63:0] qmul_fin(input logic [2*QW-1:0] acc,
                                                  input logic neg);
    logic [63:0] m;
    if (acc[2*QW-1:QW+FRAC_BITS-1] != '0) m = INT_MAX;
    else m = {1'b0, acc[QW+FRAC_BITS-2:FRAC_BITS]};
    return with_sign(m, neg);
  endfunction

  // quotient magnitude saturated to the signed range
  function automatic logic [63:0] div_fin(input logic [DIV_W-1:0] q);
    if (q[DIV_W-1:QW-1] != '0) return INT_MAX;
    return {1'b0, q[QW-2:0]};
  endfunction

  function automatic logic signed [63:0] clamp_t(input logic signed [63:0] t);
    if (t > T_LIMIT) return T_LIMIT;
    if (t < -T_LIMIT) return -T_LIMIT;
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- src/rtd_code_to_temperature_top.sv -----
// ----------------------------------------------------------------------------
// rtd_code_to_temperature_top
// Converts an RTD register word to resistance and Callendar-Van Dusen
// temperature, in Celsius or Fahrenheit, with fault and no-reading status.
// ----------------------------------------------------------------------------
// usage:
//   a request is taken on a rising edge with start high and busy low.
//   busy stays high until the result is shown; the result sits on rsp_o for
//   one cycle with done_o high, and the receiver cannot hold it off.
//   configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) is written while idle.
// sequence, from the accepting edge to the edge that takes the result:
//   fault or zero code: straight to the result.
//   quadratic root path: ratio divide, two products, square root, divide
//   and scaling product, plus a divide for Fahrenheit.
//   newton path: after a negative discriminant or root, up to 30 iterations
//   before the scaling product and the Fahrenheit divide. each product runs
//   in the bit-serial multiplier and each divide in the bit-serial divider;
//   a full newton iteration is eight products and one divide, so those two units set the timing.
//   one request at a time: a new request is not taken until busy falls.
// reset:
//   registers return to R0 100 ohm, Rref 430 ohm, two decimals, Celsius;
//   any request in flight is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module rtd_code_to_temperature_top import rtdc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  rtdc_req_t  req_i,
  output logic       done_o,
  output rtdc_rsp_t  rsp_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [19:0] cfg_wdata_i
);

  // configuration
  logic [17:0] nom_q;
  logic [19:0] rref_q;
  logic [1:0]  dec_q;
  logic        fahr_q;

  rtdc_state_e        state_q, state_d;
  logic               issued_q, issued_d;
  logic               phase_q, phase_d;
  logic [1:0]         step_q, step_d;
  logic [ITER_W-1:0]  iter_q, iter_d;
  logic               done_q, done_d;

  logic [7:0]         fault_q, fault_d;
  logic [34:0]        prod_q, prod_d;
  rtdc_status_e       status_q, status_d;
  logic signed [63:0] ratio_q, ratio_d;
  logic signed [63:0] t_q, t_d;
  logic signed [63:0] x_q, x_d;
  logic signed [63:0] p0_q, p0_d;
  logic signed [63:0] f_q, f_d;
  logic signed [63:0] temp_q, temp_d;
  rtdc_rsp_t          rsp_q, rsp_d;

  // serial units
  logic               mul_start, mul_done, mul_neg;
  logic [63:0]        mul_as, mul_bs;
  logic [2*QW-1:0]    mul_acc;
  logic signed [63:0] mul_r;
  logic               ds_start, ds_done;
  rtdc_ds_mode_e      ds_mode;
  logic [63:0]        ds_num, ds_den;
  logic [DIV_W-1:0]   ds_q;

  logic signed [63:0] u;
  logic [17:0]        nom_eff;
  logic [41:0]        cohm_sum;

  rtdc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mag64(mul_as)),
    .b_i     (mag64(mul_bs)),
    .done_o  (mul_done),
    .acc_o   (mul_acc)
  );

  rtdc_divsqrt u_divsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ds_start),
    .mode_i  (ds_mode),
    .num_i   (ds_num),
    .den_i   (ds_den),
    .done_o  (ds_done),
    .quot_o  (ds_q)
  );

  assign busy     = (state_q != ST_IDLE);
  assign u        = phase_q ? (t_q + HSTEP) : t_q;
  assign nom_eff  = (nom_q == '0) ? 18'd1 : nom_q;
  assign mul_neg  = mul_as[63] ^ mul_bs[63];
  assign mul_r    = qmul_fin(mul_acc, mul_neg);
  assign cohm_sum = ({7'b0, prod_q} * 42'd100) + 42'd1048576;

  // operand selection for the shared units
  always_comb begin
    mul_as  = '0;
    mul_bs  = '0;
    ds_mode = DS_DIV;
    ds_num  = '0;
    ds_den  = 64'd1;
    case (state_q)
      ST_DISC_A: begin
        mul_as = KA;
        mul_bs = KA;
      end
      ST_DISC_B: begin
        mul_as = KB;
        mul_bs = Q_ONE - ratio_q;
      end
      ST_POLY: begin
        if (step_q == 2'd0) begin
          mul_as = -KC;
          mul_bs = u - Q_ONE;
        end else begin
          mul_as = u;
          mul_bs = x_q;
        end
      end
      ST_SCALE: begin
        mul_as = t_q;
        if (fahr_q) mul_bs = 64'd10000;
        else if (dec_q == 2'd0) mul_bs = 64'd100;
        else if (dec_q == 2'd1) mul_bs = 64'd1000;
        else mul_bs = 64'd10000;
      end
      ST_RATIO: begin
        ds_num = {29'b0, prod_q};
        ds_den = {31'b0, nom_eff, 15'b0};
      end
      ST_SQRT: begin
        ds_mode = DS_SQRT;
        ds_num  = x_q;
      end
      ST_QDIV: begin
        ds_num = mag64(x_q);
        ds_den = KB <<< 1;
      end
      ST_NDIV: begin
        ds_num = mag64(f_q);
        ds_den = mag64(x_q);
      end
      ST_FDIV: begin
        ds_num = mag64(x_q) + 64'd250;
        ds_den = 64'd500;
      end
      default: ;
    endcase
  end

  always_comb begin
    logic signed [63:0] p, fv, dp, delta, tn, sv, tsat;
    logic [63:0]        dmag, v;
    logic signed [33:0] base, fn;

    state_d   = state_q;
    issued_d  = issued_q;
    phase_d   = phase_q;
    step_d    = step_q;
    iter_d    = iter_q;
    done_d    = 1'b0;
    fault_d   = fault_q;
    prod_d    = prod_q;
    status_d  = status_q;
    ratio_d   = ratio_q;
    t_d       = t_q;
    x_d       = x_q;
    p0_d      = p0_q;
    f_d       = f_q;
    temp_d    = temp_q;
    rsp_d     = rsp_q;
    mul_start = 1'b0;
    ds_start  = 1'b0;

    p     = mul_r + Q_ONE;
    fv    = p - ratio_q;
    dp    = p - p0_q;
    dmag  = div_fin(ds_q) >> SLOPE_SHIFT;
    delta = with_sign(dmag, f_q[63] ^ x_q[63]);
    tn    = with_sign(div_fin(ds_q), x_q[63]);
    v     = (mul_acc[63:0] + HALF) >> FRAC_BITS;
    sv    = with_sign(v, t_q[63]);
    base  = (sv[33:0] * 34'sd9) + 34'sd16000;
    if (dec_q == 2'd0) fn = base;
    else if (dec_q == 2'd1) fn = base * 34'sd10;
    else fn = base * 34'sd100;
    if (temp_q > OUT_HIGH) tsat = OUT_HIGH;
    else if (temp_q < OUT_LOW) tsat = OUT_LOW;
    else tsat = temp_q;

    unique case (state_q)
      ST_IDLE: begin
        issued_d = 1'b0;
        if (start) begin
          fault_d = req_i.fault_status;
          prod_d  = {20'b0, req_i.rtd_word[15:1]} * {15'b0, rref_q};
          temp_d  = '0;
          if (req_i.fault_status != 8'd0) begin
            status_d = STATUS_FAULT;
            state_d  = ST_OUT;
          end else if (req_i.rtd_word[15:1] == '0 || rref_q == '0) begin
            status_d = STATUS_NO_READING;
            state_d  = ST_OUT;
          end else begin
            status_d = STATUS_OK;
            state_d  = ST_RATIO;
          end
        end
      end
      ST_RATIO: begin
        if (!issued_q) begin
          ds_start = 1'b1;
          issued_d = 1'b1;
        end else if (ds_done) begin
          issued_d = 1'b0;
          ratio_d  = signed'(div_fin(ds_q));
          state_d  = ST_DISC_A;
        end
      end
      ST_DISC_A: begin
        if (!issued_q) begin
          mul_start = 1'b1;
          issued_d  = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          x_d      = mul_r;
          state_d  = ST_DISC_B;
        end
      end
      ST_DISC_B: begin
        if (!issued_q) begin
          mul_start = 1'b1;
          issued_d  = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          x_d      = x_q + (mul_r <<< 2);
          if (!x_d[63]) begin
            state_d = ST_SQRT;
          end else begin
            t_d     = T_START;
            iter_d  = '0;
            phase_d = 1'b0;
            step_d  = 2'd0;
            state_d = ST_POLY;
          end
        end
      end
      ST_SQRT: begin
        if (!issued_q) begin
          ds_start = 1'b1;
          issued_d = 1'b1;
        end else if (ds_done) begin
          issued_d = 1'b0;
          x_d      = KA - signed'(ds_q[63:0]);
          state_d  = ST_QDIV;
        end
      end
      ST_QDIV: begin
        if (!issued_q) begin
          ds_start = 1'b1;
          issued_d = 1'b1;
        end else if (ds_done) begin
          issued_d = 1'b0;
          if (tn >= -EPS) begin
            t_d     = clamp_t(tn);
            state_d = ST_SCALE;
          end else begin
            // root went negative: fall back to newton from -50 C
            t_d     = T_START;
            iter_d  = '0;
            phase_d = 1'b0;
            step_d  = 2'd0;
            state_d = ST_POLY;
          end
        end
      end
      ST_POLY: begin
        if (!issued_q) begin
          mul_start = 1'b1;
          issued_d  = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          step_d   = step_q + 2'd1;
          case (step_q)
            2'd0: x_d = mul_r;
            2'd1: x_d = mul_r - KB;
            2'd2: x_d = mul_r + KA;
            default: begin
              if (!phase_q) begin
                p0_d = p;
                f_d  = fv;
                if (mag64(fv) < EPS) state_d = ST_SCALE;
                else phase_d = 1'b1;
              end else begin
                // forward-difference slope, stored for the divide
                if (dp == '0) begin
                  state_d = ST_SCALE;
                end else begin
                  x_d     = dp;
                  state_d = ST_NDIV;
                end
              end
            end
          endcase
        end
      end
      ST_NDIV: begin
        if (!issued_q) begin
          ds_start = 1'b1;
          issued_d = 1'b1;
        end else if (ds_done) begin
          issued_d = 1'b0;
          t_d      = clamp_t(t_q - delta);
          iter_d   = iter_q + 1'b1;
          phase_d  = 1'b0;
          step_d   = 2'd0;
          if (dmag < EPS || iter_q == ITER_W'(MAX_ITERATIONS - 1)) state_d = ST_SCALE;
          else state_d = ST_POLY;
        end
      end
      ST_SCALE: begin
        if (!issued_q) begin
          mul_start = 1'b1;
          issued_d  = 1'b1;
        end else if (mul_done) begin
          issued_d = 1'b0;
          if (fahr_q) begin
            x_d     = {{30{fn[33]}}, fn};
            state_d = ST_FDIV;
          end else begin
            temp_d  = sv;
            state_d = ST_OUT;
          end
        end
      end
      ST_FDIV: begin
        if (!issued_q) begin
          ds_start = 1'b1;
          issued_d = 1'b1;
        end else if (ds_done) begin
          issued_d = 1'b0;
          temp_d   = with_sign(ds_q[DIV_W-1:FRAC_BITS], x_q[63]);
          state_d  = ST_OUT;
        end
      end
      ST_OUT: begin
        rsp_d.temperature         = tsat[18:0];
        rsp_d.resistance_centiohm = cohm_sum[41:21];
        rsp_d.status              = status_q;
        rsp_d.fault_bits          = fault_q;
        done_d                    = 1'b1;
        state_d                   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      phase_q  <= 1'b0;
      step_q   <= 2'd0;
      iter_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      phase_q  <= phase_d;
      step_q   <= step_d;
      iter_q   <= iter_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nom_q  <= 18'd6400;
      rref_q <= 20'd27520;
      dec_q  <= 2'd2;
      fahr_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (rtdc_cfg_e'(cfg_idx_i))
        CFG_NOMINAL:    nom_q  <= cfg_wdata_i[17:0];
        CFG_REFERENCE:  rref_q <= cfg_wdata_i;
        CFG_DECIMALS:   dec_q  <= cfg_wdata_i[1:0];
        CFG_FAHRENHEIT: fahr_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    fault_q  <= fault_d;
    prod_q   <= prod_d;
    status_q <= status_d;
    ratio_q  <= ratio_d;
    t_q      <= t_d;
    x_q      <= x_d;
    p0_q     <= p0_d;
    f_q      <= f_d;
    temp_q   <= temp_d;
    rsp_q    <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ----- src/rtdc_mul.sv -----
// ----------------------------------------------------------------------------
// rtdc_mul
// Bit-serial unsigned multiplier, one multiplier bit per cycle, full product.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdc_mul import rtdc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [QW-1:0]     a_i,
  input  logic [QW-1:0]     b_i,
  output logic              done_o,
  output logic [2*QW-1:0]   acc_o
);

  logic                 run_q, done_q;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic [QW-1:0]        mcand_q;
  logic [2*QW-1:0]      acc_q;
  logic [QW:0]          sum;

  assign sum = {1'b0, acc_q[2*QW-1:QW]} + (acc_q[0] ? {1'b0, mcand_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MUL_CNT_W'(QW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q   <= {{QW{1'b0}}, b_i};
      mcand_q <= a_i;
    end else if (run_q) begin
      acc_q <= {sum, acc_q[QW-1:1]};
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

// ----- src/rtdc_divsqrt.sv -----
// ----------------------------------------------------------------------------
// rtdc_divsqrt
// Shared restoring divider (one quotient bit per cycle) and square root
// (one root bit per cycle), both on the operand shifted up by the fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdc_divsqrt import rtdc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  rtdc_ds_mode_e     mode_i,
  input  logic [QW-1:0]     num_i,
  input  logic [QW-1:0]     den_i,
  output logic              done_o,
  output logic [DIV_W-1:0]  quot_o
);

  logic                run_q, done_q;
  rtdc_ds_mode_e       mode_q;
  logic [DS_CNT_W-1:0] cnt_q;
  logic [QW-1:0]       den_q;
  logic [DIV_W-1:0]    sh_q;
  logic [REM_W-1:0]    rem_q;
  logic [ROOT_W-1:0]   root_q;

  logic [QW:0]         r2d, remd;
  logic                ged;
  logic [REM_W-1:0]    r2s, trial, rems;
  logic                ges;
  logic                last;

  always_comb begin
    r2d   = {rem_q[QW-1:0], sh_q[DIV_W-1]};
    ged   = (r2d >= {1'b0, den_q});
    remd  = ged ? (r2d - {1'b0, den_q}) : r2d;
    r2s   = {rem_q[REM_W-3:0], sh_q[DIV_W-1:DIV_W-2]};
    trial = {{(REM_W-ROOT_W-2){1'b0}}, root_q, 2'b01};
    ges   = (r2s >= trial);
    rems  = ges ? (r2s - trial) : r2s;
    last  = (mode_q == DS_SQRT) ? (cnt_q == DS_CNT_W'(ROOT_W - 1))
                                : (cnt_q == DS_CNT_W'(DIV_W - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q <= mode_i;
      den_q  <= den_i;
      sh_q   <= {num_i, {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      if (mode_q == DS_SQRT) begin
        rem_q  <= rems;
        sh_q   <= {sh_q[DIV_W-3:0], 2'b00};
        root_q <= {root_q[ROOT_W-2:0], ges};
      end else begin
        rem_q <= {1'b0, remd};
        sh_q  <= {sh_q[DIV_W-2:0], ged};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = (mode_q == DS_SQRT) ? {{(DIV_W-ROOT_W){1'b0}}, root_q} : sh_q;

endmodule

`default_nettype wire

// ----- src/rtdc_checker.sv -----
// ----------------------------------------------------------------------------
// rtdc_checker
// Port-level checks on request handling and result strobing of the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module rtdc_checker import rtdc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      done_o,
  input rtdc_rsp_t rsp_o
);

  // a taken request keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but busy not raised");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // a result only closes out work that was in flight
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("result without a request in flight");

  a_err_temp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != STATUS_OK) |-> (rsp_o.temperature == '0))
    else $error("error status with nonzero temperature");

endmodule

bind rtd_code_to_temperature_top rtdc_checker u_rtdc_checker (.*);

`default_nettype wire
